// ===== rtl/pvrag_pkg.sv =====
// Shared types and constants for the planar video row address generator.
package pvrag_pkg;

    localparam int DIM_W    = 13;
    localparam int ADDR_W   = 33;
    localparam int BASE_W   = 32;
    localparam int OFF_W    = 32;
    localparam int STRIDE_W = 19;
    localparam int MB_W     = 14;
    localparam int CIDX_W   = 3;

    typedef enum logic [2:0] {
        FMT_I420 = 3'd0,
        FMT_YV12 = 3'd1,
        FMT_YUY2 = 3'd2,
        FMT_NV12 = 3'd3,
        FMT_TM12 = 3'd4
    } fmt_t;

    localparam logic [CIDX_W-1:0] REG_FORMAT       = 3'd0;
    localparam logic [CIDX_W-1:0] REG_WIDTH        = 3'd1;
    localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 3'd2;
    localparam logic [CIDX_W-1:0] REG_OUT_HEIGHT   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_FRAME_BASE   = 3'd4;

    localparam logic [1:0] PLANE_LUMA = 2'd0;
    localparam logic [1:0] PLANE_CB   = 2'd1;
    localparam logic [1:0] PLANE_CR   = 2'd2;

    typedef struct packed {
        logic [2:0]       format;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] frame_height;
        logic [DIM_W-1:0] out_height;
    } geom_t;

    // Offset is ma*mb + j*stride.
    typedef struct packed {
        logic                ok;
        logic [1:0]          plane;
        logic [DIM_W-1:0]    j;
        logic [STRIDE_W-1:0] stride;
        logic [DIM_W-1:0]    ma;
        logic [MB_W-1:0]     mb;
    } cls_t;

endpackage

// ===== rtl/pvrag_classify.sv =====
// Row classification: plane, in-plane row, stride and plane base factors.
module pvrag_classify #(
    parameter int MAX_DIM = 4096
) (
    input  logic [pvrag_pkg::DIM_W-1:0] row,
    input  pvrag_pkg::geom_t            geom,
    output pvrag_pkg::cls_t             cls
);

    localparam int DW = pvrag_pkg::DIM_W;

    function automatic logic [DW-1:0] sat_dim(input logic [DW-1:0] v);
        logic [DW:0] lim;
        begin
            lim = (DW+1)'(MAX_DIM);
            sat_dim = ({1'b0, v} > lim) ? lim[DW-1:0] : v;
        end
    endfunction

    logic [DW-1:0] w, h, rh, half;
    logic [DW:0]   w14, sy_t, wr8_t, ys_t;
    logic [DW:0]   sy;
    logic [DW-1:0] suv;
    logic [DW+1:0] ys;
    logic [DW:0]   r14, rh14, half14, rh_half, rh_2half;
    logic [8:0]    tiles, luma_rows;
    logic [5:0]    chroma_rows;
    logic [DW:0]   tm_end;

    always_comb
    begin
        w      = sat_dim(geom.width);
        h      = sat_dim(geom.frame_height);
        rh     = sat_dim(geom.out_height);
        half   = rh >> 1;
        w14    = {1'b0, w};
        sy_t   = w14 + (DW+1)'(3);
        sy     = {sy_t[DW:2], 2'b00};
        wr8_t  = w14 + (DW+1)'(7);
        suv    = wr8_t[DW:1] & ~DW'(3);
        ys_t   = {w, 1'b0} + (DW+1)'(3);
        ys     = {1'b0, ys_t[DW:2], 2'b00};
        r14    = {1'b0, row};
        rh14   = {1'b0, rh};
        half14 = {1'b0, half};
        rh_half  = rh14 + half14;
        rh_2half = rh_half + half14;
        tiles       = 9'(h >> 5);
        luma_rows   = 9'((10'(tiles) + 10'd1) >> 1);
        chroma_rows = 6'(h >> 7);
        tm_end      = (DW+1)'(luma_rows) + (DW+1)'(chroma_rows);

        cls = '0;
        case (geom.format)
            pvrag_pkg::FMT_I420, pvrag_pkg::FMT_YV12:
            begin
                if (r14 < rh14)
                begin
                    cls.ok     = 1'b1;
                    cls.plane  = pvrag_pkg::PLANE_LUMA;
                    cls.j      = row;
                    cls.stride = pvrag_pkg::STRIDE_W'(sy);
                end
                else if (r14 < rh_2half)
                begin
                    cls.ok     = 1'b1;
                    cls.stride = pvrag_pkg::STRIDE_W'(suv);
                    cls.ma     = h;
                    cls.mb     = pvrag_pkg::MB_W'(sy);
                    // The second chroma plane of I420 and the first of YV12
                    // sit half a plane past the chroma base.
                    if (r14 < rh_half)
                    begin
                        cls.plane = pvrag_pkg::PLANE_CB;
                        cls.j = DW'(r14 - rh14)
                              + ((geom.format == pvrag_pkg::FMT_YV12) ? half : '0);
                    end
                    else
                    begin
                        cls.plane = pvrag_pkg::PLANE_CR;
                        cls.j = DW'(r14 - rh_half)
                              + ((geom.format == pvrag_pkg::FMT_I420) ? half : '0);
                    end
                end
            end
            pvrag_pkg::FMT_YUY2:
            begin
                if (r14 < rh14)
                begin
                    cls.ok     = 1'b1;
                    cls.j      = row;
                    cls.stride = pvrag_pkg::STRIDE_W'(ys);
                end
            end
            pvrag_pkg::FMT_NV12:
            begin
                // The chroma plane follows the luma rows directly, so both
                // planes reduce to row times width.
                if (r14 < rh_half)
                begin
                    cls.ok     = 1'b1;
                    cls.plane  = (r14 < rh14) ? pvrag_pkg::PLANE_LUMA
                                              : pvrag_pkg::PLANE_CB;
                    cls.j      = row;
                    cls.stride = pvrag_pkg::STRIDE_W'(w);
                end
            end
            pvrag_pkg::FMT_TM12:
            begin
                if (r14 < (DW+1)'(luma_rows))
                begin
                    cls.ok     = 1'b1;
                    cls.j      = row;
                    cls.stride = {w, 6'b0};
                end
                else if (r14 < tm_end)
                begin
                    cls.ok     = 1'b1;
                    cls.plane  = pvrag_pkg::PLANE_CB;
                    cls.j      = DW'(r14 - (DW+1)'(luma_rows));
                    cls.stride = pvrag_pkg::STRIDE_W'({w[DW-1:1], 5'b0});
                    cls.ma     = h;
                    cls.mb     = pvrag_pkg::MB_W'(w);
                end
            end
            default:
            begin
                cls = '0;
            end
        endcase
    end

endmodule

// ===== rtl/planar_video_row_address_gen_top.sv =====
// Top level of the planar video row address generator.
// A row request is taken on any cycle that start is high; busy never rises, so
// one word per cycle may be issued back to back. Each word's result is shown
// with done high for a single cycle, in request order. The five register
// stages are input capture, row classification, the two plane offset
// multiplies, the offset sum and the frame base add. Register writes are
// always accepted (cfg_ready high) and should only be made while no request
// is in flight.
module planar_video_row_address_gen_top #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pvrag_pkg::DIM_W-1:0]         row_index,
    output logic                                done,
    output logic [pvrag_pkg::ADDR_W-1:0]        row_address,
    output logic [1:0]                          plane,
    output logic                                valid_res,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pvrag_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [pvrag_pkg::BASE_W-1:0]        cfg_data
);

    localparam int DW = pvrag_pkg::DIM_W;
    localparam int OW = pvrag_pkg::OFF_W;

    logic [2:0]                  format_reg;
    logic [DW-1:0]               width_reg, frame_height_reg, out_height_reg;
    logic [pvrag_pkg::BASE_W-1:0] frame_base_reg;

    logic                        v1_reg, v2_reg, v3_reg, v4_reg, done_reg;
    logic [DW-1:0]               row_reg;
    pvrag_pkg::cls_t             cls_next, cls_reg;
    pvrag_pkg::geom_t            geom;
    logic [OW-1:0]               prod_row_reg, prod_base_reg, off_reg;
    logic                        ok3_reg, ok4_reg;
    logic [1:0]                  plane3_reg, plane4_reg;
    logic [OW-1:0]               prod_row_next, prod_base_next;
    logic [pvrag_pkg::ADDR_W-1:0] row_address_reg, row_address_next;
    logic [1:0]                  plane_reg;
    logic                        valid_res_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg       <= pvrag_pkg::FMT_I420;
            width_reg        <= DW'(640);
            frame_height_reg <= DW'(480);
            out_height_reg   <= DW'(480);
            frame_base_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pvrag_pkg::REG_FORMAT:       format_reg       <= cfg_data[2:0];
                pvrag_pkg::REG_WIDTH:        width_reg        <= cfg_data[DW-1:0];
                pvrag_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DW-1:0];
                pvrag_pkg::REG_OUT_HEIGHT:   out_height_reg   <= cfg_data[DW-1:0];
                pvrag_pkg::REG_FRAME_BASE:   frame_base_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        geom.format       = format_reg;
        geom.width        = width_reg;
        geom.frame_height = frame_height_reg;
        geom.out_height   = out_height_reg;
    end

    pvrag_classify #(
        .MAX_DIM (MAX_DIM)
    ) u_classify (
        .row  (row_reg),
        .geom (geom),
        .cls  (cls_next)
    );

    always_comb
    begin
        prod_row_next  = OW'(cls_reg.j) * OW'(cls_reg.stride);
        prod_base_next = OW'(cls_reg.ma) * OW'(cls_reg.mb);
        row_address_next = ok4_reg ? ({1'b0, frame_base_reg} + pvrag_pkg::ADDR_W'(off_reg))
                                   : '0;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            row_reg <= row_index;
        end
        if (v1_reg)
        begin
            cls_reg <= cls_next;
        end
        if (v2_reg)
        begin
            prod_row_reg  <= prod_row_next;
            prod_base_reg <= prod_base_next;
            ok3_reg       <= cls_reg.ok;
            plane3_reg    <= cls_reg.plane;
        end
        if (v3_reg)
        begin
            off_reg    <= prod_row_reg + prod_base_reg;
            ok4_reg    <= ok3_reg;
            plane4_reg <= plane3_reg;
        end
        if (v4_reg)
        begin
            row_address_reg <= row_address_next;
            plane_reg       <= ok4_reg ? plane4_reg : pvrag_pkg::PLANE_LUMA;
            valid_res_reg   <= ok4_reg;
        end
    end

    assign done        = done_reg;
    assign row_address = row_address_reg;
    assign plane       = plane_reg;
    assign valid_res   = valid_res_reg;

endmodule
